FILE: hdl/booth_radix2_multiplier_defines.svh
// Assertion macros used by the multiplier top level.
`ifndef BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH
`define BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BRM_ASSERT_SAME(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define BRM_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/brm_pkg.sv
`default_nettype none
package brm_pkg;

    localparam int WIDTH  = 32;
    localparam int DATA_W = 32;
    localparam int CW     = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef struct packed {
        logic load;
        logic step;
        logic add;
        logic sub;
    } t_ctl;

endpackage
`default_nettype wire

FILE: hdl/brm_cell.sv
`default_nettype none
module brm_cell (
    input  wire            i_clk,
    input  wire brm_pkg::t_ctl i_ctl,
    input  wire            i_load_m,
    input  wire            i_load_q,
    input  wire            i_carry,
    input  wire            i_a_shift,
    input  wire            i_q_shift,
    output logic           o_carry,
    output logic           o_sum,
    output logic           o_q
);

    logic r_a;
    logic r_q;
    logic r_m;
    logic w_b;

    assign w_b     = (i_ctl.add | i_ctl.sub) & (r_m ^ i_ctl.sub);
    assign o_sum   = r_a ^ w_b ^ i_carry;
    assign o_carry = (r_a & w_b) | (r_a & i_carry) | (w_b & i_carry);
    assign o_q     = r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= 1'b0;
            r_q <= i_load_q;
            r_m <= i_load_m;
        end else if (i_ctl.step) begin
            r_a <= i_a_shift;
            r_q <= i_q_shift;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/brm_row.sv
`default_nettype none
module brm_row (
    input  wire                        i_clk,
    input  wire brm_pkg::t_ctl         i_ctl,
    input  wire [brm_pkg::WIDTH-1:0]   i_load_m,
    input  wire [brm_pkg::WIDTH-1:0]   i_load_q,
    output logic [brm_pkg::WIDTH-1:0]  o_q,
    output logic [brm_pkg::WIDTH-1:0]  o_q_next
);

    localparam int W = brm_pkg::WIDTH;

    logic [W:0]   w_carry;
    logic [W-1:0] w_sum;
    logic [W-1:0] w_a_shift;

    assign w_carry[0] = i_ctl.sub;

    // arithmetic right shift of the sum; low sum bit moves into the multiplier top
    assign w_a_shift = {w_sum[W-1], w_sum[W-1:1]};
    assign o_q_next  = {w_sum[0], o_q[W-1:1]};

    genvar gi;
    generate
        for (gi = 0; gi < W; gi++) begin : g_cell
            brm_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (i_ctl),
                .i_load_m  (i_load_m[gi]),
                .i_load_q  (i_load_q[gi]),
                .i_carry   (w_carry[gi]),
                .i_a_shift (w_a_shift[gi]),
                .i_q_shift (o_q_next[gi]),
                .o_carry   (w_carry[gi+1]),
                .o_sum     (w_sum[gi]),
                .o_q       (o_q[gi])
            );
        end
    endgenerate

endmodule
`default_nettype wire

FILE: hdl/booth_radix2_multiplier.sv
// Channel   Direction  tdata fields (low bit up)
// s_axis    in         multiplicand [31:0], multiplier [63:32]
// m_axis    out        product_low [31:0]
//
// One item is one load beat, then one Booth step per cycle through the cell row,
// one multiplier bit each; the last step, which waits for a free output register,
// writes the result. The step counter ends the run after the last multiplier bit.
// i_rst_n is synchronous, active low; it clears the state and the output valid.
// A full output register stalls only the last step; a new beat is taken
// while a result still waits.
`default_nettype none
`include "booth_radix2_multiplier_defines.svh"
module booth_radix2_multiplier (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // multiplicand [31:0], multiplier [63:32]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // product_low [31:0]
);

    localparam int W  = brm_pkg::WIDTH;
    localparam int DW = brm_pkg::DATA_W;
    localparam int CW = brm_pkg::CW;
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_prev;
    logic          n_prev;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [DW-1:0] r_out_data;
    logic [DW-1:0] n_out_data;

    brm_pkg::t_ctl w_ctl;
    logic [W-1:0]  w_q;
    logic [W-1:0]  w_q_next;
    logic [W-1:0]  w_load_m;
    logic [W-1:0]  w_load_q;
    logic [63:0]   w_ext_m;
    logic [63:0]   w_ext_q;
    logic [DW-1:0] w_result;
    logic          w_accept;
    logic          w_last;
    logic          w_slot_free;

    assign w_ext_m  = {{32{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
    assign w_ext_q  = {{32{s_axis_tdata[63]}}, s_axis_tdata[63:32]};
    assign w_load_m = w_ext_m[W-1:0];
    assign w_load_q = w_ext_q[W-1:0];

    generate
        if (W >= DW) begin : g_out_cut
            assign w_result = w_q_next[DW-1:0];
        end else begin : g_out_ext
            assign w_result = {{(DW - W){w_q_next[W-1]}}, w_q_next};
        end
    endgenerate

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_last      = (r_count == LAST);
    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_comb begin
        w_ctl.load = w_accept;
        w_ctl.step = (r_state == ST_RUN) && (!w_last || w_slot_free);
        w_ctl.sub  = w_ctl.step && w_q[0] && !r_prev;
        w_ctl.add  = w_ctl.step && !w_q[0] && r_prev;
    end

    brm_row u_row (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_load_m (w_load_m),
        .i_load_q (w_load_q),
        .o_q      (w_q),
        .o_q_next (w_q_next)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_prev      = r_prev;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                    n_count = '0;
                    n_prev  = 1'b0;
                end
            end
            ST_RUN: begin
                if (w_ctl.step) begin
                    n_prev  = w_q[0];
                    n_count = r_count + 1'b1;
                    if (w_last) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                        n_out_data  = w_result;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_prev      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    `BRM_ASSERT_NEXT(a_accept_starts, w_accept, r_state == ST_RUN && r_count == '0 && !r_prev, "accepted beat did not start a run")
    `BRM_ASSERT_NEXT(a_count_advance, r_state == ST_RUN && !w_last, r_count == $past(r_count) + 1'b1, "step counter skipped")
    `BRM_ASSERT_SAME(a_valid_source, $rose(r_out_valid), $past(r_state == ST_RUN) && $past(r_count == LAST), "result appeared before the last step")
    `BRM_ASSERT_NEXT(a_result_hold, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_out_data), "waiting result changed")

endmodule
`default_nettype wire
